// ----- rtl/core/lph_pkg.sv -----
`timescale 1ns / 1ps
package lph_pkg;

    localparam int TABLE_SIZE = 64;
    localparam int KEY_BITS   = 32;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ENTRY_W    = KEY_BITS + IDX_W;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_READ_ONLY = 3'd6;
    localparam logic [2:0] ST_NULL_KEY  = 3'd7;

    localparam logic [0:0] REG_WRITES_ENABLED = 1'd0;
    localparam logic [0:0] REG_LOAD_LIMIT     = 1'd1;

    typedef struct packed {
        logic load;
        logic rd_i;
        logic inc_i;
        logic inc_n;
        logic n_one;
        logic clr_valid_i;
        logic wr_i;
        logic cap_move;
        logic inc_j;
        logic wr_j;
        logic cnt_inc;
        logic cnt_dec;
    } lph_cmd_t;

    typedef struct packed {
        logic valid_i;
        logic valid_j;
        logic n_full;
        logic key_eq;
        logic over_limit;
    } lph_stat_t;

endpackage

// ----- rtl/core/lph_ram.sv -----
`timescale 1ns / 1ps
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ----- rtl/core/lph_dp.sv -----
`timescale 1ns / 1ps
module lph_dp
    import lph_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lph_cmd_t            cmd,
    input  logic [KEY_BITS-1:0] key,
    input  logic [31:0]         key_hash,
    input  logic [CNT_W-1:0]    load_limit,
    output lph_stat_t           stat,
    output logic [CNT_W-1:0]    entry_count
);

    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    j_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [IDX_W-1:0]    home_reg;
    logic [KEY_BITS-1:0] mkey_reg;
    logic [IDX_W-1:0]    mhome_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [TABLE_SIZE-1:0] valid_reg;

    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [ENTRY_W-1:0]  rdata;

    assign we    = cmd.wr_i | cmd.wr_j;
    assign waddr = cmd.wr_i ? i_reg : j_reg;
    assign wdata = cmd.wr_i ? {key_reg, home_reg} : {mkey_reg, mhome_reg};

    lph_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_i),
        .raddr(i_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key;
            home_reg <= key_hash[IDX_W-1:0];
            i_reg    <= key_hash[IDX_W-1:0];
            n_reg    <= '0;
        end
        else
        begin
            if (cmd.inc_i)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.n_one)
            begin
                n_reg <= CNT_W'(1);
            end
            else if (cmd.inc_n)
            begin
                n_reg <= n_reg + 1'b1;
            end
        end
        if (cmd.cap_move)
        begin
            mkey_reg  <= rdata[ENTRY_W-1:IDX_W];
            mhome_reg <= rdata[IDX_W-1:0];
            j_reg     <= rdata[IDX_W-1:0];
        end
        else if (cmd.inc_j)
        begin
            j_reg <= j_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.clr_valid_i)
            begin
                valid_reg[i_reg] <= 1'b0;
            end
            if (cmd.wr_i)
            begin
                valid_reg[i_reg] <= 1'b1;
            end
            if (cmd.wr_j)
            begin
                valid_reg[j_reg] <= 1'b1;
            end
            if (cmd.cnt_inc)
            begin
                total_reg <= total_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                total_reg <= total_reg - 1'b1;
            end
        end
    end

    assign stat.valid_i    = valid_reg[i_reg];
    assign stat.valid_j    = valid_reg[j_reg];
    assign stat.n_full     = (n_reg == CNT_W'(TABLE_SIZE));
    assign stat.key_eq     = (rdata[ENTRY_W-1:IDX_W] == key_reg);
    assign stat.over_limit = (total_reg >= load_limit);
    assign entry_count     = total_reg;

endmodule

// ----- rtl/core/lph_ctrl.sv -----
`timescale 1ns / 1ps
module lph_ctrl
    import lph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  logic       key_absent,
    input  logic       writes_enabled,
    input  lph_stat_t  stat,
    output lph_cmd_t   cmd,
    output logic       busy,
    output logic       done,
    output logic [2:0] status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRB    = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_MV_CHK = 3'd3;
    localparam logic [2:0] S_MV_LD  = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] op_reg;
    logic [1:0] op_next;
    logic [2:0] status_reg;
    logic [2:0] status_next;
    logic       is_write;

    assign is_write = (mode == MODE_ADD) || (mode == MODE_REMOVE);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = mode;
                    if (is_write && !writes_enabled)
                    begin
                        status_next = ST_READ_ONLY;
                        state_next  = S_DONE;
                    end
                    else if (key_absent)
                    begin
                        status_next = ST_NULL_KEY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PRB;
                    end
                end
            end
            S_PRB:
            begin
                if (stat.n_full || !stat.valid_i)
                begin
                    state_next = S_DONE;
                    if (op_reg == MODE_ADD)
                    begin
                        if (stat.over_limit || stat.n_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_i    = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            status_next = ST_ADDED;
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    cmd.rd_i   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.key_eq)
                begin
                    if (op_reg == MODE_ADD)
                    begin
                        status_next = ST_PRESENT;
                        state_next  = S_DONE;
                    end
                    else if (op_reg == MODE_REMOVE)
                    begin
                        cmd.clr_valid_i = 1'b1;
                        cmd.cnt_dec     = 1'b1;
                        cmd.inc_i       = 1'b1;
                        cmd.n_one       = 1'b1;
                        status_next     = ST_REMOVED;
                        state_next      = S_MV_CHK;
                    end
                    else
                    begin
                        status_next = ST_FOUND;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    cmd.inc_i  = 1'b1;
                    cmd.inc_n  = 1'b1;
                    state_next = S_PRB;
                end
            end
            S_MV_CHK:
            begin
                if (stat.n_full || !stat.valid_i)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_i        = 1'b1;
                    cmd.clr_valid_i = 1'b1;
                    state_next      = S_MV_LD;
                end
            end
            S_MV_LD:
            begin
                cmd.cap_move = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (!stat.valid_j)
                begin
                    cmd.wr_j   = 1'b1;
                    cmd.inc_i  = 1'b1;
                    cmd.inc_n  = 1'b1;
                    state_next = S_MV_CHK;
                end
                else
                begin
                    cmd.inc_j = 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= MODE_ADD;
            status_reg <= ST_ADDED;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign status = status_reg;

endmodule

// ----- rtl/core/linear_probe_hash_set.sv -----
`timescale 1ns / 1ps
// Hash set of up to 64 keys held in a linearly probed table.
// A request word (mode, key, key_hash, key_absent) is taken at a rising edge
// where start is high and busy is low. Mode 0 adds, 1 removes, 2 or 3 queries.
// Its result word (status, entry_count) is shown for exactly one cycle with
// result_valid high; the receiver cannot stall and must take it then.
// A refused request (read-only or null key) goes straight to its result;
// any other request reads and compares each occupied slot from the key's
// home slot until it finds the key, meets a free slot or has passed every slot.
// A remove then takes each later entry of the cluster out and reinserts it at
// the first free slot found from its own home slot, until a free slot ends the
// cluster or every slot has been passed. Busy falls in the cycle after the result.
// Only one request is in flight at a time.
// The APB port holds writes_enabled at 0x0 and load_limit at 0x4; write them
// only while busy is low.
// Reset clears all valid bits and the entry count at once, sets
// writes_enabled to 1 and load_limit to 48; no clearing pass is needed.
module linear_probe_hash_set
    import lph_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [KEY_BITS-1:0] key,
    input  logic [31:0]         key_hash,
    input  logic                key_absent,
    output logic                result_valid,
    output logic [2:0]          status,
    output logic [CNT_W-1:0]    entry_count
);

    logic             we_reg;
    logic [CNT_W-1:0] limit_reg;
    logic             ctrl_busy;
    lph_cmd_t         cmd;
    lph_stat_t        stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            we_reg    <= 1'b1;
            limit_reg <= CNT_W'(48);
        end
        else if (psel && penable && pwrite && (paddr[1:0] == 2'b00))
        begin
            unique case (paddr[2])
                REG_WRITES_ENABLED: we_reg    <= pwdata[0];
                REG_LOAD_LIMIT:     limit_reg <= pwdata[CNT_W-1:0];
                default:            we_reg    <= we_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_WRITES_ENABLED: prdata = {31'd0, we_reg};
            REG_LOAD_LIMIT:     prdata = {{(32 - CNT_W){1'b0}}, limit_reg};
            default:            prdata = '0;
        endcase
    end

    lph_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .mode          (mode),
        .key_absent    (key_absent),
        .writes_enabled(we_reg),
        .stat          (stat),
        .cmd           (cmd),
        .busy          (ctrl_busy),
        .done          (result_valid),
        .status        (status)
    );

    lph_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key        (key),
        .key_hash   (key_hash),
        .load_limit (limit_reg),
        .stat       (stat),
        .entry_count(entry_count)
    );

    assign busy = ctrl_busy;

endmodule

// ----- rtl/core/lph_checker.sv -----
`timescale 1ns / 1ps
module lph_checker
    import lph_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input logic [2:0]       status,
    input logic [CNT_W-1:0] entry_count
);

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("Result word shown while not busy.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("Result strobe held for more than one cycle.");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted request did not make the block busy.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> entry_count <= CNT_W'(TABLE_SIZE))
        else $error("Entry count beyond table size.");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_ADDED |-> entry_count == $past(entry_count) + 1'b1)
        else $error("Added word did not raise the entry count by one.");

endmodule

bind linear_probe_hash_set lph_checker u_lph_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .result_valid(result_valid),
    .status      (status),
    .entry_count (entry_count)
);
